>>> hw/rtl/orsfe_pkg.sv
// ----------------------------------------------------------------------------
// orsfe_pkg: shared types and constants of the OOK remote-switch frame encoder
// Transaction structs, field widths, register indexes and small helpers.
// ----------------------------------------------------------------------------
package orsfe_pkg;

   localparam int EMITTER_BITS = 26;
   localparam int UNIT_BITS    = 4;
   localparam int DATA_BITS    = EMITTER_BITS + 2 + UNIT_BITS;
   localparam int SYM_W        = $clog2(2 * DATA_BITS);
   localparam int BIT_IDX_W    = $clog2(DATA_BITS);
   localparam int TICK_W       = 16;
   localparam int REP_W        = 4;
   localparam int CSR_IDX_W    = 3;

   localparam logic MODE_TICK  = 1'b0;
   localparam logic MODE_START = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PULSE_HIGH   = 3'd0,
      CSR_SHORT_LOW    = 3'd1,
      CSR_LONG_LOW     = 3'd2,
      CSR_SYNC_HIGH    = 3'd3,
      CSR_FIRST_LATCH  = 3'd4,
      CSR_SECOND_LATCH = 3'd5,
      CSR_FRAME_GAP    = 3'd6,
      CSR_REPEAT_TOTAL = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                    mode;
      logic [EMITTER_BITS-1:0] emitter_id;
      logic [UNIT_BITS-1:0]    unit_code;
      logic                    group;
      logic                    turn_on;
   } req_type;

   typedef struct packed {
      logic             pin_level;
      logic             busy_res;
      logic             done_res;
      logic [REP_W-1:0] frame_number;
   } rsp_type;

   // A zero duration counts as one tick.
   function automatic logic [TICK_W-1:0] at_least_one_tick(input logic [TICK_W-1:0] v);
      at_least_one_tick = (v == '0) ? TICK_W'(1) : v;
   endfunction

   function automatic logic [REP_W-1:0] at_least_one_rep(input logic [REP_W-1:0] v);
      at_least_one_rep = (v == '0) ? REP_W'(1) : v;
   endfunction

endpackage

>>> hw/rtl/orsfe_rsp_queue.sv
// ----------------------------------------------------------------------------
// orsfe_rsp_queue: two-entry result buffer
// Holds finished results so the encoder keeps accepting while the sink stalls.
// ----------------------------------------------------------------------------
module orsfe_rsp_queue
   import orsfe_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic [1:0] count_ff, count_in;
   rsp_type    slot0_ff, slot0_in;
   rsp_type    slot1_ff, slot1_in;
   logic       pop;

   assign pop       = (count_ff != 2'd0) && !rsp_stall;
   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data  = slot0_ff;

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      if (pop) begin
         // advance the head
         if (count_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else begin
            slot0_in = push_data;
         end
         if (push && count_ff == 2'd2) begin
            slot1_in = push_data;
         end
      end else if (push) begin
         if (count_ff == 2'd0) begin
            slot0_in = push_data;
         end else begin
            slot1_in = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

>>> hw/rtl/ook_remote_switch_frame_encoder.sv
// ----------------------------------------------------------------------------
// ook_remote_switch_frame_encoder: on-off-keyed remote-switch frame generator
// Turns start and tick transactions into the transmitter pin waveform.
// ----------------------------------------------------------------------------
// Every request transaction yields exactly one result transaction. A start
// transaction (mode 1) latches a 32-bit command word (emitter id, group flag,
// on flag, unit code forced to 0 for groups) and begins the first frame; a
// start while busy is ignored. A tick transaction (mode 0) consumes one tick
// at the current pin level. Each frame is a latch (high, long low, high, low),
// 64 data symbols (each bit b sent as b then not b, a symbol being a high pulse
// and a short or long low), an end high pulse and a low gap; the frame is sent
// repeat_total times and done_res pulses on the tick the last gap ends. Segment
// lengths come from the CSRs, read when each segment begins; a zero length is
// one tick and a zero repeat count is one frame. Throughput is one transaction
// per clock while req_stall is low: the segment counter and phase sequencer
// update at acceptance, and the result enters a two-entry output buffer that
// presents it on rsp_ after earlier results. req_stall rises only while both
// buffer entries hold results the sink has not taken. CSRs are written through
// csr_we/csr_index/csr_wdata at any time: a write during a command changes only
// the segments that begin after it, and repeat_total is read only at start.
// ----------------------------------------------------------------------------
module ook_remote_switch_frame_encoder
   import orsfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICK_W-1:0]    csr_wdata
);

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_L1_HIGH  = 3'd1,
      PH_L1_LOW   = 3'd2,
      PH_L2_HIGH  = 3'd3,
      PH_L2_LOW   = 3'd4,
      PH_DATA     = 3'd5,
      PH_END_HIGH = 3'd6,
      PH_GAP      = 3'd7
   } phase_type;

   // Configuration registers
   logic [TICK_W-1:0] pulse_high_ff, short_low_ff, long_low_ff, sync_high_ff;
   logic [TICK_W-1:0] first_latch_ff, second_latch_ff, frame_gap_ff;
   logic [REP_W-1:0]  repeat_total_ff;

   // Frame state
   phase_type             phase_ff, phase_in;
   logic [DATA_BITS-1:0]  frame_bits_ff, frame_bits_in;
   logic [SYM_W-1:0]      sym_ff, sym_in;
   logic                  half_low_ff, half_low_in;
   logic [TICK_W-1:0]     dur_ff, dur_in;
   logic [REP_W-1:0]      repeat_left_ff, repeat_left_in;
   logic                  level_ff, level_in;
   logic [REP_W-1:0]      frame_count_ff, frame_count_in;

   logic                  take_req;
   logic                  queue_full;
   logic                  done_in;
   logic [TICK_W-1:0]     dur_dec;
   logic [REP_W-1:0]      repeat_dec;
   logic [BIT_IDX_W-1:0]  bit_idx;
   logic                  sym_value;
   logic [UNIT_BITS-1:0]  unit_sel;
   rsp_type               rsp_next;

   // Hold the request while both result entries are occupied.
   assign req_stall = queue_full;
   assign take_req  = req_valid && !req_stall;

   // ------------------------------------------------------------------
   // CSR writes
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pulse_high_ff   <= TICK_W'(310);
         short_low_ff    <= TICK_W'(310);
         long_low_ff     <= TICK_W'(1340);
         sync_high_ff    <= TICK_W'(275);
         first_latch_ff  <= TICK_W'(9900);
         second_latch_ff <= TICK_W'(2675);
         frame_gap_ff    <= TICK_W'(10000);
         repeat_total_ff <= REP_W'(6);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_PULSE_HIGH:   pulse_high_ff   <= csr_wdata;
            CSR_SHORT_LOW:    short_low_ff    <= csr_wdata;
            CSR_LONG_LOW:     long_low_ff     <= csr_wdata;
            CSR_SYNC_HIGH:    sync_high_ff    <= csr_wdata;
            CSR_FIRST_LATCH:  first_latch_ff  <= csr_wdata;
            CSR_SECOND_LATCH: second_latch_ff <= csr_wdata;
            CSR_FRAME_GAP:    frame_gap_ff    <= csr_wdata;
            CSR_REPEAT_TOTAL: repeat_total_ff <= csr_wdata[REP_W-1:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Sequencer next state
   // ------------------------------------------------------------------
   // Data bit for the current symbol pair, inverted for the second symbol.
   assign bit_idx   = BIT_IDX_W'(DATA_BITS - 1) - sym_ff[SYM_W-1:1];
   assign sym_value = frame_bits_ff[bit_idx] ^ sym_ff[0];
   assign dur_dec   = dur_ff - TICK_W'(1);
   assign repeat_dec = repeat_left_ff - REP_W'(1);
   assign unit_sel  = req_data.group ? '0 : req_data.unit_code;

   always_comb begin
      phase_in       = phase_ff;
      frame_bits_in  = frame_bits_ff;
      sym_in         = sym_ff;
      half_low_in    = half_low_ff;
      dur_in         = dur_ff;
      repeat_left_in = repeat_left_ff;
      level_in       = level_ff;
      frame_count_in = frame_count_ff;
      done_in        = 1'b0;

      if (req_data.mode == MODE_START) begin
         // Latch a new command only when idle; drop it otherwise.
         if (phase_ff == PH_IDLE) begin
            frame_bits_in  = {req_data.emitter_id, req_data.group, req_data.turn_on,
                              unit_sel};
            repeat_left_in = at_least_one_rep(repeat_total_ff);
            frame_count_in = '0;
            sym_in         = '0;
            half_low_in    = 1'b0;
            phase_in       = PH_L1_HIGH;
            level_in       = 1'b1;
            dur_in         = at_least_one_tick(sync_high_ff);
         end
      end else if (phase_ff != PH_IDLE) begin
         dur_in = dur_dec;
         if (dur_dec == '0) begin
            // Segment over: advance to the next one.
            case (phase_ff)
               PH_L1_HIGH: begin
                  phase_in = PH_L1_LOW;
                  level_in = 1'b0;
                  dur_in   = at_least_one_tick(first_latch_ff);
               end
               PH_L1_LOW: begin
                  phase_in = PH_L2_HIGH;
                  level_in = 1'b1;
                  dur_in   = at_least_one_tick(sync_high_ff);
               end
               PH_L2_HIGH: begin
                  phase_in = PH_L2_LOW;
                  level_in = 1'b0;
                  dur_in   = at_least_one_tick(second_latch_ff);
               end
               PH_L2_LOW: begin
                  phase_in    = PH_DATA;
                  sym_in      = '0;
                  half_low_in = 1'b0;
                  level_in    = 1'b1;
                  dur_in      = at_least_one_tick(pulse_high_ff);
               end
               PH_DATA: begin
                  if (!half_low_ff) begin
                     half_low_in = 1'b1;
                     level_in    = 1'b0;
                     dur_in      = at_least_one_tick(sym_value ? long_low_ff
                                                               : short_low_ff);
                  end else if (sym_ff != SYM_W'(2 * DATA_BITS - 1)) begin
                     sym_in      = sym_ff + SYM_W'(1);
                     half_low_in = 1'b0;
                     level_in    = 1'b1;
                     dur_in      = at_least_one_tick(pulse_high_ff);
                  end else begin
                     half_low_in = 1'b0;
                     phase_in    = PH_END_HIGH;
                     level_in    = 1'b1;
                     dur_in      = at_least_one_tick(sync_high_ff);
                  end
               end
               PH_END_HIGH: begin
                  phase_in = PH_GAP;
                  level_in = 1'b0;
                  dur_in   = at_least_one_tick(frame_gap_ff);
               end
               PH_GAP: begin
                  repeat_left_in = repeat_dec;
                  if (repeat_dec == '0) begin
                     phase_in       = PH_IDLE;
                     level_in       = 1'b0;
                     dur_in         = '0;
                     frame_count_in = '0;
                     done_in        = 1'b1;
                  end else begin
                     frame_count_in = frame_count_ff + REP_W'(1);
                     phase_in       = PH_L1_HIGH;
                     level_in       = 1'b1;
                     dur_in         = at_least_one_tick(sync_high_ff);
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
                  level_in = 1'b0;
                  dur_in   = '0;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         sym_ff         <= '0;
         half_low_ff    <= 1'b0;
         dur_ff         <= '0;
         repeat_left_ff <= '0;
         level_ff       <= 1'b0;
         frame_count_ff <= '0;
      end else if (take_req) begin
         phase_ff       <= phase_in;
         sym_ff         <= sym_in;
         half_low_ff    <= half_low_in;
         dur_ff         <= dur_in;
         repeat_left_ff <= repeat_left_in;
         level_ff       <= level_in;
         frame_count_ff <= frame_count_in;
      end
      if (take_req) begin
         frame_bits_ff <= frame_bits_in;
      end
   end

   // ------------------------------------------------------------------
   // Result transaction
   // ------------------------------------------------------------------
   always_comb begin
      rsp_next.pin_level    = level_in;
      rsp_next.busy_res     = (phase_in != PH_IDLE);
      rsp_next.done_res     = done_in;
      rsp_next.frame_number = (phase_in != PH_IDLE) ? frame_count_in : '0;
   end

   orsfe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (take_req),
      .push_data (rsp_next),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !level_ff && frame_count_ff == '0)
      else $error("idle sequencer drives the pin or keeps a frame count");

   a_busy_duration: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> dur_ff != '0)
      else $error("active segment with zero ticks left");

   a_start_latch: assert property (@(posedge clock) disable iff (reset)
      take_req && req_data.mode == MODE_START && phase_ff == PH_IDLE
      |=> phase_ff == PH_L1_HIGH && level_ff)
      else $error("start from idle did not open the first latch pulse");

   a_done_ends: assert property (@(posedge clock) disable iff (reset)
      take_req && done_in |=> phase_ff == PH_IDLE && $past(phase_ff) == PH_GAP)
      else $error("done reported outside the end of the last gap");

endmodule
